// ===== rtl/core/blpg_pkg.sv =====
// ----------------------------------------------------------------------------
// blpg_pkg
// shared constants and helpers for the line pixel generator
// ----------------------------------------------------------------------------
package blpg_pkg;

   // command codes on the input channel
   localparam logic OP_LINE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // fixed field widths
   localparam int COLOUR_BITS = 8;
   localparam int STEP_BITS   = 2;

   // width of one queued command for a given coordinate width:
   // op, cur_x, cur_y, major, minor, error (coord+2), step_x, step_y,
   // swapped flag, colour
   function automatic int entry_bits(input int coord_bits);
      entry_bits = 1 + 4 * coord_bits + (coord_bits + 2) + 2 * STEP_BITS + 1 + COLOUR_BITS;
   endfunction

endpackage

// ===== rtl/core/blpg_setup.sv =====
// ----------------------------------------------------------------------------
// blpg_setup
// classifies an incoming beat and works out the line setup (deltas, step
// signs, axis swap, initial error term) for new-line commands
// ----------------------------------------------------------------------------
module blpg_setup #(
   parameter int COORD_BITS = 10
) (
   input  logic                                        op,
   input  logic [COORD_BITS-1:0]                       x_start,
   input  logic [COORD_BITS-1:0]                       y_start,
   input  logic [COORD_BITS-1:0]                       x_end,
   input  logic [COORD_BITS-1:0]                       y_end,
   input  logic [blpg_pkg::COLOUR_BITS-1:0]            colour_in,
   output logic [blpg_pkg::entry_bits(COORD_BITS)-1:0] entry
);
   import blpg_pkg::*;

   localparam int EW = COORD_BITS + 2;

   typedef struct packed {
      logic                   op;
      logic [COORD_BITS-1:0]  cur_x;
      logic [COORD_BITS-1:0]  cur_y;
      logic [COORD_BITS-1:0]  major;
      logic [COORD_BITS-1:0]  minor;
      logic [EW-1:0]          err;
      logic [STEP_BITS-1:0]   step_x;
      logic [STEP_BITS-1:0]   step_y;
      logic                   swapped;
      logic [COLOUR_BITS-1:0] colour;
   } entry_type;

   logic [COORD_BITS:0]   ddx;
   logic [COORD_BITS:0]   ddy;
   logic [COORD_BITS:0]   ndx;
   logic [COORD_BITS:0]   ndy;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  steep;
   entry_type             ent;

   // signed deltas and their magnitudes
   always_comb begin
      ddx = {1'b0, x_end} - {1'b0, x_start};
      ddy = {1'b0, y_end} - {1'b0, y_start};
      ndx = '0 - ddx;
      ndy = '0 - ddy;
      adx = ddx[COORD_BITS] ? ndx[COORD_BITS-1:0] : ddx[COORD_BITS-1:0];
      ady = ddy[COORD_BITS] ? ndy[COORD_BITS-1:0] : ddy[COORD_BITS-1:0];
      steep = ady > adx;
   end

   // assemble the queued command
   always_comb begin
      ent.op      = op;
      ent.cur_x   = x_start;
      ent.cur_y   = y_start;
      ent.major   = steep ? ady : adx;
      ent.minor   = steep ? adx : ady;
      ent.swapped = steep;
      ent.colour  = colour_in;
      ent.err     = {1'b0, ent.minor, 1'b0} - {2'b00, ent.major};
      if (ddx[COORD_BITS]) begin
         ent.step_x = 2'b11;
      end else if (ddx != '0) begin
         ent.step_x = 2'b01;
      end else begin
         ent.step_x = 2'b00;
      end
      if (ddy[COORD_BITS]) begin
         ent.step_y = 2'b11;
      end else if (ddy != '0) begin
         ent.step_y = 2'b01;
      end else begin
         ent.step_y = 2'b00;
      end
      entry = ent;
   end

endmodule

// ===== rtl/core/blpg_queue.sv =====
// ----------------------------------------------------------------------------
// blpg_queue
// short command queue between the setup front and the stepping back end
// ----------------------------------------------------------------------------
module blpg_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import blpg_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // handshake and pointer update
   always_comb begin
      push_ready = count_ff != FULL_CNT;
      pop_valid  = count_ff != '0;
      pop_data   = mem[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/blpg_stepper.sv =====
// ----------------------------------------------------------------------------
// blpg_stepper
// holds the active line, steps it one pixel per tick command and drives the
// registered result channel
// ----------------------------------------------------------------------------
module blpg_stepper #(
   parameter int COORD_BITS = 10
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        q_valid,
   output logic                                        q_ready,
   input  logic [blpg_pkg::entry_bits(COORD_BITS)-1:0] q_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [COORD_BITS-1:0]                       rsp_pixel_x,
   output logic [COORD_BITS-1:0]                       rsp_pixel_y,
   output logic [blpg_pkg::COLOUR_BITS-1:0]            rsp_pixel_colour,
   output logic                                        rsp_last_pixel
);
   import blpg_pkg::*;

   localparam int EW = COORD_BITS + 2;

   typedef struct packed {
      logic                   op;
      logic [COORD_BITS-1:0]  cur_x;
      logic [COORD_BITS-1:0]  cur_y;
      logic [COORD_BITS-1:0]  major;
      logic [COORD_BITS-1:0]  minor;
      logic [EW-1:0]          err;
      logic [STEP_BITS-1:0]   step_x;
      logic [STEP_BITS-1:0]   step_y;
      logic                   swapped;
      logic [COLOUR_BITS-1:0] colour;
   } entry_type;

   entry_type              head;
   logic                   active_ff;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  major_ff;
   logic [COORD_BITS-1:0]  minor_ff;
   logic [EW-1:0]          err_ff, err_in;
   logic [EW-1:0]          err_mid;
   logic [STEP_BITS-1:0]   step_x_ff;
   logic [STEP_BITS-1:0]   step_y_ff;
   logic                   swapped_ff;
   logic [COORD_BITS-1:0]  left_ff, left_in;
   logic [COLOUR_BITS-1:0] colour_ff;
   logic                   rsp_valid_ff;
   logic [COORD_BITS-1:0]  pix_x_ff;
   logic [COORD_BITS-1:0]  pix_y_ff;
   logic [COLOUR_BITS-1:0] pix_colour_ff;
   logic                   last_ff;
   logic                   is_tick;
   logic                   out_free;
   logic                   emit;
   logic                   load;
   logic                   err_ge;
   logic                   move_x;
   logic                   move_y;
   logic [COORD_BITS-1:0]  sx_ext;
   logic [COORD_BITS-1:0]  sy_ext;

   // pop and emit decisions
   always_comb begin
      head     = entry_type'(q_data);
      is_tick  = head.op == OP_TICK;
      out_free = !rsp_valid_ff || rsp_ready;
      q_ready  = !is_tick || !active_ff || out_free;
      emit     = q_valid && is_tick && active_ff && out_free;
      load     = q_valid && !is_tick;
   end

   // one bresenham step
   always_comb begin
      err_ge  = !err_ff[EW-1];
      err_mid = err_ge ? (err_ff - {1'b0, major_ff, 1'b0}) : err_ff;
      err_in  = err_mid + {1'b0, minor_ff, 1'b0};
      move_x  = swapped_ff ? err_ge : 1'b1;
      move_y  = swapped_ff ? 1'b1 : err_ge;
      sx_ext  = {{(COORD_BITS - STEP_BITS){step_x_ff[STEP_BITS-1]}}, step_x_ff};
      sy_ext  = {{(COORD_BITS - STEP_BITS){step_y_ff[STEP_BITS-1]}}, step_y_ff};
      cur_x_in = cur_x_ff + (move_x ? sx_ext : '0);
      cur_y_in = cur_y_ff + (move_y ? sy_ext : '0);
      left_in  = left_ff - 1'b1;
   end

   // line state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            active_ff <= head.major != '0;
         end else if (emit) begin
            active_ff <= left_in != '0;
         end
      end
      if (load) begin
         cur_x_ff   <= head.cur_x;
         cur_y_ff   <= head.cur_y;
         major_ff   <= head.major;
         minor_ff   <= head.minor;
         err_ff     <= head.err;
         step_x_ff  <= head.step_x;
         step_y_ff  <= head.step_y;
         swapped_ff <= head.swapped;
         left_ff    <= head.major;
         colour_ff  <= head.colour;
      end else if (emit) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         err_ff   <= err_in;
         left_ff  <= left_in;
      end
      if (emit) begin
         pix_x_ff      <= cur_x_ff;
         pix_y_ff      <= cur_y_ff;
         pix_colour_ff <= colour_ff;
         last_ff       <= left_ff == COORD_BITS'(1);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = pix_x_ff;
   assign rsp_pixel_y      = pix_y_ff;
   assign rsp_pixel_colour = pix_colour_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

// ===== rtl/core/bresenham_line_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_unit
// line pixel generator, all octants, one pixel per tick command
// ----------------------------------------------------------------------------
// request channel (req_*): op selects a new line (start, end, colour) or a
// tick. a new line emits nothing and replaces any line in progress; a tick
// emits the next pixel of the active line, or nothing when no line is
// active. the end point is not drawn and a zero-length line draws nothing.
// response channel (rsp_*): pixel coordinates, colour and a last-pixel flag.
// an accepted tick is stored in the command queue, then the stepper registers
// its pixel in the output register that drives rsp_*.
// throughput: one beat per clock on both channels while rsp_ready stays
// high; the stepper loop (error update and coordinate step) sets that rate.
// when rsp_ready is low, the output register holds its pixel, the stepper
// stops at the next tick and the two-entry queue fills; req_ready then
// drops until the receiver takes a pixel.
// reset: synchronous; clears the queue, the active-line flag and rsp_valid.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_unit #(
   parameter int COORD_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [COORD_BITS-1:0]            req_x_start,
   input  logic [COORD_BITS-1:0]            req_y_start,
   input  logic [COORD_BITS-1:0]            req_x_end,
   input  logic [COORD_BITS-1:0]            req_y_end,
   input  logic [blpg_pkg::COLOUR_BITS-1:0] req_colour_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [COORD_BITS-1:0]            rsp_pixel_x,
   output logic [COORD_BITS-1:0]            rsp_pixel_y,
   output logic [blpg_pkg::COLOUR_BITS-1:0] rsp_pixel_colour,
   output logic                             rsp_last_pixel
);
   import blpg_pkg::*;

   localparam int ENTRY_W = entry_bits(COORD_BITS);

   logic [ENTRY_W-1:0] setup_entry;
   logic [ENTRY_W-1:0] q_data;
   logic               q_valid;
   logic               q_ready;

   // front: classify and set up
   blpg_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .op        (req_op),
      .x_start   (req_x_start),
      .y_start   (req_y_start),
      .x_end     (req_x_end),
      .y_end     (req_y_end),
      .colour_in (req_colour_in),
      .entry     (setup_entry)
   );

   // command queue
   blpg_queue #(
      .DATA_W(ENTRY_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (setup_entry),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // back: stepping and output register
   blpg_stepper #(
      .COORD_BITS(COORD_BITS)
   ) u_stepper (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ready          (q_ready),
      .q_data           (q_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // the back end only stalls the queue behind a held pixel
   assert property (@(posedge clock) disable iff (reset)
      (q_valid && !q_ready) |-> (rsp_valid && !rsp_ready))
      else $error("stepper stalled without a held pixel");

   // a full queue always presents a command
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("request stalled while queue is empty");

   // no pixel is shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid after reset");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// line pixel generator: line and tick commands are streamed in with random
// gaps; a behavioral line stepper predicts every pixel, and each pixel beat is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CW         = 10;
   localparam int CB         = blpg_pkg::COLOUR_BITS;
   localparam int CMAX       = (1 << CW) - 1;
   localparam int RAND_ITEMS = 1600;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN      = 16;
   localparam int MAX_REPORT = 40;

   typedef struct {
      logic          op;
      logic [CW-1:0] xs;
      logic [CW-1:0] ys;
      logic [CW-1:0] xe;
      logic [CW-1:0] ye;
      logic [CB-1:0] colour;
   } line_cmd_type;

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CB-1:0] colour;
      logic          is_last;
   } pixel_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_op = blpg_pkg::OP_TICK;
   logic [CW-1:0] req_x_start = '0;
   logic [CW-1:0] req_y_start = '0;
   logic [CW-1:0] req_x_end = '0;
   logic [CW-1:0] req_y_end = '0;
   logic [CB-1:0] req_colour_in = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CW-1:0] rsp_pixel_x;
   logic [CW-1:0] rsp_pixel_y;
   logic [CB-1:0] rsp_pixel_colour;
   logic          rsp_last_pixel;

   line_cmd_type cmd_queue[$];
   pixel_type    pixel_queue[$];
   line_cmd_type cmd_on_bus;
   int           err_count = 0;
   int           cycle_count = 0;
   logic         quiet_tail = 1'b0;

   // stepper state of the predicted line
   logic          ln_active = 1'b0;
   logic [CW-1:0] ln_x = '0;
   logic [CW-1:0] ln_y = '0;
   int            ln_major = 0;
   int            ln_minor = 0;
   int            ln_err = 0;
   int            ln_step_x = 0;
   int            ln_step_y = 0;
   logic          ln_steep = 1'b0;
   logic [CW-1:0] ln_left = '0;
   logic [CB-1:0] ln_colour = '0;

   bresenham_line_pixel_generator_unit #(
      .COORD_BITS (CW)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_colour_in    (req_colour_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int sign_of(input int v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
   endfunction

   // advance the predicted line by one accepted command
   function automatic void trace_line_step(input line_cmd_type c);
      int        ddx;
      int        ddy;
      int        adx;
      int        ady;
      pixel_type px;
      if (c.op == blpg_pkg::OP_LINE) begin
         ddx       = int'(c.xe) - int'(c.xs);
         ddy       = int'(c.ye) - int'(c.ys);
         adx       = (ddx < 0) ? -ddx : ddx;
         ady       = (ddy < 0) ? -ddy : ddy;
         ln_x      = c.xs;
         ln_y      = c.ys;
         ln_step_x = sign_of(ddx);
         ln_step_y = sign_of(ddy);
         ln_colour = c.colour;
         // y becomes the major axis only when strictly longer
         ln_steep  = (ady > adx);
         ln_major  = ln_steep ? ady : adx;
         ln_minor  = ln_steep ? adx : ady;
         ln_err    = 2 * ln_minor - ln_major;
         ln_left   = CW'(ln_major);
         ln_active = (ln_major != 0);
      end else if (ln_active) begin
         px.x       = ln_x;
         px.y       = ln_y;
         px.colour  = ln_colour;
         px.is_last = (ln_left == 1);
         pixel_queue.push_back(px);
         // minor axis step when the decision term is non-negative
         if (ln_err >= 0) begin
            if (ln_steep) ln_x = ln_x + CW'(ln_step_x);
            else ln_y = ln_y + CW'(ln_step_y);
            ln_err = ln_err - 2 * ln_major;
         end
         if (ln_steep) ln_y = ln_y + CW'(ln_step_y);
         else ln_x = ln_x + CW'(ln_step_x);
         ln_err  = ln_err + 2 * ln_minor;
         ln_left = ln_left - 1'b1;
         if (ln_left == 0) ln_active = 1'b0;
      end
   endfunction

   function automatic void push_line(input int xs, input int ys, input int xe, input int ye,
                                     input int colour);
      line_cmd_type c;
      c.op     = blpg_pkg::OP_LINE;
      c.xs     = CW'(xs);
      c.ys     = CW'(ys);
      c.xe     = CW'(xe);
      c.ye     = CW'(ye);
      c.colour = CB'(colour);
      cmd_queue.push_back(c);
   endfunction

   // ticks carry random payload, which the block must ignore
   function automatic void push_ticks(input int n);
      line_cmd_type c;
      for (int i = 0; i < n; i++) begin
         c.op     = blpg_pkg::OP_TICK;
         c.xs     = CW'($urandom);
         c.ys     = CW'($urandom);
         c.xe     = CW'($urandom);
         c.ye     = CW'($urandom);
         c.colour = CB'($urandom);
         cmd_queue.push_back(c);
      end
   endfunction

   function automatic int near_coord(input int base);
      int v;
      v = base + $urandom_range(0, 48) - 24;
      if (v < 0) v = 0;
      if (v > CMAX) v = CMAX;
      return v;
   endfunction

   // stimulus and end of run
   initial begin
      int           counted;
      int           xs;
      int           ys;
      int           xe;
      int           ye;
      int           span;
      int           ticks;
      int           pick;
      int           dx;
      int           dy;
      line_cmd_type noise;

      // directed: tick while idle, zero length, equal deltas, steep,
      // overrun ticks, interrupted line, vertical line, field extremes
      push_ticks(1);
      push_line(5, 5, 5, 5, 255);
      push_ticks(1);
      push_line(0, CMAX, 3, CMAX - 3, 0);
      push_ticks(3);
      push_line(CMAX, 0, CMAX - 2, 4, 255);
      push_ticks(5);
      push_line(10, 10, 16, 12, 'hA5);
      push_ticks(2);
      push_line(20, 30, 20, 25, 'h5A);
      push_ticks(5);

      // random: mostly well-formed lines with their ticks, some noise
      counted = 0;
      while (counted < RAND_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            noise.op     = 1'($urandom_range(0, 1));
            noise.xs     = CW'($urandom);
            noise.ys     = CW'($urandom);
            noise.xe     = CW'($urandom);
            noise.ye     = CW'($urandom);
            noise.colour = CB'($urandom);
            cmd_queue.push_back(noise);
            if (noise.op == blpg_pkg::OP_LINE) counted++;
         end else begin
            xs = $urandom_range(0, CMAX);
            ys = $urandom_range(0, CMAX);
            if (pick < 9) begin
               xe = $urandom_range(0, CMAX);
               ye = $urandom_range(0, CMAX);
            end else begin
               xe = near_coord(xs);
               ye = near_coord(ys);
            end
            dx   = (xe > xs) ? xe - xs : xs - xe;
            dy   = (ye > ys) ? ye - ys : ys - ye;
            span = (dx > dy) ? dx : dy;
            pick = $urandom_range(0, 99);
            if (span > 200) ticks = $urandom_range(0, 200);
            else if (pick < 70) ticks = span;
            else if (pick < 85) ticks = $urandom_range(0, span);
            else ticks = span + $urandom_range(1, 3);
            push_line(xs, ys, xe, ye, $urandom_range(0, 255));
            push_ticks(ticks);
            counted += 1 + ((ticks < span) ? ticks : span);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sample on the falling edge so the driver's updates have settled
      while (cmd_queue.size() != 0 || req_valid) @(negedge clock);
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (DRAIN) @(posedge clock);
      if (err_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // command driver
   int   tx_gap = 0;
   int   tx_mode_left = 0;
   logic tx_idle_en = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         quiet_tail <= (cmd_queue.size() < 250);
         if (tx_mode_left == 0) begin
            tx_mode_left = $urandom_range(24, 120);
            tx_idle_en   = ($urandom_range(0, 2) != 0);
         end else begin
            tx_mode_left--;
         end
         if (req_valid && req_ready) trace_line_step(cmd_on_bus);
         // slot is free when nothing is offered or the beat just went
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0 && tx_idle_en && !quiet_tail &&
                         $urandom_range(0, 4) == 0) begin
               tx_gap = $urandom_range(1, 11) - 1;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               cmd_on_bus = cmd_queue.pop_front();
               req_valid     <= 1'b1;
               req_op        <= cmd_on_bus.op;
               req_x_start   <= cmd_on_bus.xs;
               req_y_start   <= cmd_on_bus.ys;
               req_x_end     <= cmd_on_bus.xe;
               req_y_end     <= cmd_on_bus.ye;
               req_colour_in <= cmd_on_bus.colour;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         err_count++;
         if (err_count <= MAX_REPORT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // pixel monitor and receiver stalls
   int        rx_gap = 0;
   int        rx_hold = 0;
   int        rx_mode_left = 0;
   logic      rx_idle_en = 1'b1;
   int        pixels_seen = 0;
   pixel_type want_px;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORT)
                  $display("%0t: unexpected pixel beat, expected none, actual x=%0d y=%0d",
                           $time, rsp_pixel_x, rsp_pixel_y);
            end else begin
               want_px = pixel_queue.pop_front();
               check_field("pixel_x", want_px.x, rsp_pixel_x);
               check_field("pixel_y", want_px.y, rsp_pixel_y);
               check_field("pixel_colour", want_px.colour, rsp_pixel_colour);
               check_field("last_pixel", want_px.is_last, rsp_last_pixel);
            end
            // long back-pressure so the block fills and stalls its input
            if (pixels_seen == 300 || pixels_seen == 1100) rx_hold = 120;
         end
         if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(24, 120);
            rx_idle_en   = ($urandom_range(0, 2) != 0);
         end else begin
            rx_mode_left--;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_en && !quiet_tail && $urandom_range(0, 4) == 0) begin
            rx_gap = $urandom_range(1, 11) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
